// ----- sv/assert_macros.svh -----
// Assertion helpers for the frame parser checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define CFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define CFP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/cfp_pkg.sv -----
package cfp_pkg;

    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_P         = 8'h50;
    localparam logic [7:0] CH_UNDER     = 8'h5F;
    localparam logic [7:0] CH_EQ        = 8'h3D;
    localparam logic [7:0] CH_BANG      = 8'h21;
    localparam logic [7:0] CH_AT        = 8'h40;
    localparam logic [7:0] CH_F         = 8'h46;
    localparam logic [7:0] CH_L         = 8'h6C;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_G         = 8'h67;
    localparam logic [7:0] DIGIT_OFFSET = 8'd48;
    localparam logic [7:0] COUNT_MAX    = 8'hFF;

    typedef enum logic [6:0] {
        G_HASH    = 7'b0000001,
        G_P       = 7'b0000010,
        G_ID1     = 7'b0000100,
        G_UNDER   = 7'b0001000,
        G_ID2     = 7'b0010000,
        G_EQ      = 7'b0100000,
        G_PAYLOAD = 7'b1000000
    } gain_state_t;

    typedef enum logic [6:0] {
        F_AT      = 7'b0000001,
        F_F       = 7'b0000010,
        F_L       = 7'b0000100,
        F_A       = 7'b0001000,
        F_G       = 7'b0010000,
        F_EQ      = 7'b0100000,
        F_PAYLOAD = 7'b1000000
    } flag_state_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data;
        logic [7:0] index;
        logic       done;
        logic [7:0] length;
        logic [7:0] first_id;
        logic [7:0] second_id;
    } gain_res_t;

    typedef struct packed {
        logic       value_valid;
        logic [7:0] value;
        logic [7:0] index;
        logic       done;
    } flag_res_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + 8'd1;
    endfunction

endpackage

// ----- sv/cfp_gain_fsm.sv -----
module cfp_gain_fsm
    import cfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output gain_res_t  res
);

    gain_state_t state_reg, state_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  second_reg, second_next;
    logic [7:0]  digit;

    assign digit = rx_byte - DIGIT_OFFSET;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        first_next  = first_reg;
        second_next = second_reg;
        res         = '0;
        case (state_reg)
            G_HASH:
            begin
                if (rx_byte == CH_HASH) state_next = G_P;
            end
            G_P:
            begin
                if (rx_byte == CH_P) state_next = G_ID1;
            end
            G_ID1:
            begin
                first_next = digit;
                state_next = G_UNDER;
            end
            G_UNDER:
            begin
                if (rx_byte == CH_UNDER) state_next = G_ID2;
            end
            G_ID2:
            begin
                second_next = digit;
                state_next  = G_EQ;
            end
            G_EQ:
            begin
                if (rx_byte == CH_EQ) state_next = G_PAYLOAD;
            end
            G_PAYLOAD:
            begin
                if (rx_byte == CH_BANG)
                begin
                    res.done   = 1'b1;
                    res.length = count_reg;
                    count_next = '0;
                    state_next = G_HASH;
                end
                else
                begin
                    res.byte_valid = 1'b1;
                    res.data       = rx_byte;
                    res.index      = count_reg;
                    count_next     = sat_inc(count_reg);
                end
            end
            default:
            begin
            end
        endcase
        res.first_id  = first_next;
        res.second_id = second_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= G_HASH;
            count_reg  <= '0;
            first_reg  <= '0;
            second_reg <= '0;
        end
        else if (step)
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

endmodule

// ----- sv/cfp_flag_fsm.sv -----
module cfp_flag_fsm
    import cfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output flag_res_t  res
);

    flag_state_t state_reg, state_next;
    logic [7:0]  count_reg, count_next;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        res        = '0;
        case (state_reg)
            F_AT:
            begin
                if (rx_byte == CH_AT) state_next = F_F;
            end
            F_F:
            begin
                if (rx_byte == CH_F) state_next = F_L;
            end
            F_L:
            begin
                if (rx_byte == CH_L) state_next = F_A;
            end
            F_A:
            begin
                if (rx_byte == CH_A) state_next = F_G;
            end
            F_G:
            begin
                if (rx_byte == CH_G) state_next = F_EQ;
            end
            F_EQ:
            begin
                if (rx_byte == CH_EQ) state_next = F_PAYLOAD;
            end
            F_PAYLOAD:
            begin
                if (rx_byte == CH_BANG)
                begin
                    res.done   = 1'b1;
                    count_next = '0;
                    state_next = F_AT;
                end
                else
                begin
                    res.value_valid = 1'b1;
                    res.value       = rx_byte - DIGIT_OFFSET;
                    res.index       = count_reg;
                    count_next      = sat_inc(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_AT;
            count_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- sv/command_frame_parser_core.sv -----
// Command frame parser core.
// Input channel: in_valid/in_ready carry one received serial byte (rx_byte)
// per item. Output channel: out_valid/out_ready carry one result item per
// input item, holding the gain-frame and flag-frame reports for that byte.
// Both recognizers see every byte; one byte may advance both.
// Latency: a result appears in the cycle after its byte is accepted
// (one register between the recognizers and the output ports).
// Throughput: one item per cycle. Each recognizer is a one-hot state
// register plus a saturating 8-bit counter, updated in the accept cycle.
// Stall: the result register holds its item until out_ready; a new byte is
// still taken in the same cycle the held result leaves, so in_ready drops
// only while a result waits and out_ready is low.
// Reset (rst_n, asynchronous): both recognizers return to their idle
// phase, counters and identifiers clear to zero, no result is pending.
module command_frame_parser_core
    import cfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // byte input
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    // result output
    output logic       out_valid,
    input  logic       out_ready,
    output logic       gain_byte_valid,
    output logic [7:0] gain_byte,
    output logic [7:0] gain_byte_index,
    output logic       gain_frame_done,
    output logic [7:0] gain_length,
    output logic [7:0] first_id,
    output logic [7:0] second_id,
    output logic       flag_value_valid,
    output logic [7:0] flag_value,
    output logic [7:0] flag_value_index,
    output logic       flag_frame_done
);

    logic      accept;
    gain_res_t gain_res;
    flag_res_t flag_res;
    gain_res_t gain_out_reg;
    flag_res_t flag_out_reg;
    logic      out_valid_reg, out_valid_next;

    // Output register may be refilled in the cycle it drains.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    cfp_gain_fsm u_gain
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .rx_byte (rx_byte),
        .res     (gain_res)
    );

    cfp_flag_fsm u_flag
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .rx_byte (rx_byte),
        .res     (flag_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Payload: loaded only on accept, no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gain_out_reg <= gain_res;
            flag_out_reg <= flag_res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign gain_byte_valid  = gain_out_reg.byte_valid;
    assign gain_byte        = gain_out_reg.data;
    assign gain_byte_index  = gain_out_reg.index;
    assign gain_frame_done  = gain_out_reg.done;
    assign gain_length      = gain_out_reg.length;
    assign first_id         = gain_out_reg.first_id;
    assign second_id        = gain_out_reg.second_id;
    assign flag_value_valid = flag_out_reg.value_valid;
    assign flag_value       = flag_out_reg.value;
    assign flag_value_index = flag_out_reg.index;
    assign flag_frame_done  = flag_out_reg.done;

endmodule

// ----- sv/cfp_checker.sv -----
`include "assert_macros.svh"

module cfp_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       gain_byte_valid,
    input logic [7:0] gain_byte,
    input logic       gain_frame_done,
    input logic [7:0] gain_length,
    input logic [7:0] first_id,
    input logic       flag_value_valid,
    input logic [7:0] flag_value,
    input logic [7:0] flag_value_index,
    input logic       flag_frame_done
);

    // Nothing pending once an edge has seen reset low.
    `CFP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid during reset")

    // A stalled result holds its contents.
    `CFP_ASSERT(a_stall_hold,
        out_valid && !out_ready |=> out_valid && $stable(gain_byte) &&
        $stable(flag_value) && $stable(first_id),
        "stalled result changed")

    // Only a waiting result may block the input.
    `CFP_ASSERT(a_ready_when_free, !out_valid || out_ready |-> in_ready,
        "input blocked without a pending result")

    // A byte is either payload or the closer, never both; quiet fields are zero.
    `CFP_ASSERT(a_gain_excl,
        out_valid |-> !(gain_byte_valid && gain_frame_done) &&
        (gain_frame_done || gain_length == 8'd0),
        "gain report inconsistent")

    `CFP_ASSERT(a_flag_excl,
        out_valid |-> !(flag_value_valid && flag_frame_done) &&
        (flag_value_valid || (flag_value == 8'd0 && flag_value_index == 8'd0)),
        "flag report inconsistent")

endmodule

bind command_frame_parser_core cfp_checker u_cfp_checker (.*);

// ----- verif/command_frame_parser_core_tb.sv -----
// Self-checking bench for command_frame_parser_core.
// The driver offers bytes from a pending queue. The monitor predicts each
// accepted byte and checks the result items in order.
module command_frame_parser_core_tb;
    import cfp_pkg::*;

    localparam int ITEM_TARGET    = 1600;    // stimulus stops growing past this
    localparam int QUIET_TAIL     = 150;     // last bytes go through with no idling
    localparam int HOLD_CYCLES    = 60;      // long receiver hold-off
    localparam int DRAIN_CYCLES   = 4;       // margin after the last result arrives
    localparam int TIMEOUT_CYCLES = 500_000;
    localparam int MAX_PRINTED    = 50;

    // Expected result item: gain side and flag side of one byte.
    typedef struct packed {
        gain_res_t gain;
        flag_res_t flag;
    } byte_report_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       gain_byte_valid;
    logic [7:0] gain_byte;
    logic [7:0] gain_byte_index;
    logic       gain_frame_done;
    logic [7:0] gain_length;
    logic [7:0] first_id;
    logic [7:0] second_id;
    logic       flag_value_valid;
    logic [7:0] flag_value;
    logic [7:0] flag_value_index;
    logic       flag_frame_done;

    command_frame_parser_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .gain_byte_valid  (gain_byte_valid),
        .gain_byte        (gain_byte),
        .gain_byte_index  (gain_byte_index),
        .gain_frame_done  (gain_frame_done),
        .gain_length      (gain_length),
        .first_id         (first_id),
        .second_id        (second_id),
        .flag_value_valid (flag_value_valid),
        .flag_value       (flag_value),
        .flag_value_index (flag_value_index),
        .flag_frame_done  (flag_frame_done)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Bytes waiting to be offered, and predicted results waiting to arrive.
    logic [7:0]   rx_pending[$];
    byte_report_t expected_reports[$];

    // Predictor copy of both recognizers.
    gain_state_t gain_st;
    flag_state_t flag_st;
    logic [7:0]  gain_cnt;
    logic [7:0]  flag_cnt;
    logic [7:0]  id_first;
    logic [7:0]  id_second;

    int   total_bytes = 0;
    int   bytes_in = 0;
    int   reports_out = 0;
    int   mismatch_count = 0;
    int   gain_frames = 0;
    int   flag_frames = 0;
    int   saturated_reports = 0;
    int   hold_offs = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    logic byte_taken = 1'b0;
    logic hold_off = 1'b0;

    // Random idling only outside the tail, and every third stretch of 128
    // bytes runs with none at all.
    logic idle_window;
    assign idle_window = (bytes_in + QUIET_TAIL < total_bytes) && ((bytes_in / 128) % 3 != 2);

    // ---------------------------------------------------------------
    // Predictor: advances both recognizers by one byte and returns the
    // result item that byte must produce.
    // ---------------------------------------------------------------
    function automatic byte_report_t predict_byte(input logic [7:0] b);
        byte_report_t r;
        logic [7:0]   digit;
        r     = '0;
        digit = b - DIGIT_OFFSET;

        // Gain frame: #P<id>_<id>=payload!
        case (gain_st)
            G_HASH:  if (b == CH_HASH) gain_st = G_P;
            G_P:     if (b == CH_P) gain_st = G_ID1;
            G_ID1:
            begin
                // any byte is taken as an identifier
                id_first = digit;
                gain_st  = G_UNDER;
            end
            G_UNDER: if (b == CH_UNDER) gain_st = G_ID2;
            G_ID2:
            begin
                id_second = digit;
                gain_st   = G_EQ;
            end
            G_EQ:    if (b == CH_EQ) gain_st = G_PAYLOAD;
            G_PAYLOAD:
            begin
                if (b == CH_BANG)
                begin
                    r.gain.done   = 1'b1;
                    r.gain.length = gain_cnt;
                    gain_cnt      = 8'd0;
                    gain_st       = G_HASH;
                end
                else
                begin
                    r.gain.byte_valid = 1'b1;
                    r.gain.data       = b;
                    r.gain.index      = gain_cnt;
                    if (gain_cnt != COUNT_MAX)
                        gain_cnt = gain_cnt + 8'd1;
                end
            end
            default: ;
        endcase
        r.gain.first_id  = id_first;
        r.gain.second_id = id_second;

        // Flag frame: @Flag=payload!  (sees the same byte)
        case (flag_st)
            F_AT:    if (b == CH_AT) flag_st = F_F;
            F_F:     if (b == CH_F) flag_st = F_L;
            F_L:     if (b == CH_L) flag_st = F_A;
            F_A:     if (b == CH_A) flag_st = F_G;
            F_G:     if (b == CH_G) flag_st = F_EQ;
            F_EQ:    if (b == CH_EQ) flag_st = F_PAYLOAD;
            F_PAYLOAD:
            begin
                if (b == CH_BANG)
                begin
                    r.flag.done = 1'b1;
                    flag_cnt    = 8'd0;
                    flag_st     = F_AT;
                end
                else
                begin
                    r.flag.value_valid = 1'b1;
                    r.flag.value       = digit;
                    r.flag.index       = flag_cnt;
                    if (flag_cnt != COUNT_MAX)
                        flag_cnt = flag_cnt + 8'd1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic compare_field(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %02h want %02h",
                                      reports_out, field, got, want));
    endtask

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            rx_pending.push_back(s[i]);
    endtask

    // Payload bytes: anything but the closing '!'.
    task automatic push_payload(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_BANG);
            rx_pending.push_back(b);
        end
    endtask

    task automatic push_noise(input int n);
        for (int i = 0; i < n; i++)
            rx_pending.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic push_gain_frame(input int n);
        rx_pending.push_back(CH_HASH);
        rx_pending.push_back(CH_P);
        rx_pending.push_back(8'($urandom_range(0, 255)));
        rx_pending.push_back(CH_UNDER);
        rx_pending.push_back(8'($urandom_range(0, 255)));
        rx_pending.push_back(CH_EQ);
        push_payload(n);
        rx_pending.push_back(CH_BANG);
    endtask

    task automatic push_flag_frame(input int n);
        push_text("@Flag=");
        push_payload(n);
        rx_pending.push_back(CH_BANG);
    endtask

    // ---------------------------------------------------------------
    // Driver: presents the next pending byte at the falling edge, holds it
    // until taken, and idles in random bursts.
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin : byte_driver
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'h00;
            send_gap <= 0;
        end
        else if (!in_valid || byte_taken)
        begin
            if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (rx_pending.size() == 0)
                in_valid <= 1'b0;
            else if (idle_window && $urandom_range(0, 9) == 0)
            begin
                send_gap <= $urandom_range(0, 14);
                in_valid <= 1'b0;
            end
            else
            begin
                in_valid <= 1'b1;
                rx_byte  <= rx_pending.pop_front();
            end
        end
    end

    // Receiver: random stall bursts, overridden by the long hold-off.
    always @(negedge clk)
    begin : result_receiver
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else if (recv_gap != 0)
        begin
            recv_gap  <= recv_gap - 1;
            out_ready <= 1'b0;
        end
        else if (idle_window && $urandom_range(0, 9) == 0)
        begin
            recv_gap  <= $urandom_range(0, 14);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Long hold-offs: the sender keeps offering, so the single result
    // register fills and in_ready must drop until out_ready returns.
    initial
    begin : long_hold_off
        int mark;
        for (mark = 300; mark <= 900; mark += 600)
        begin
            while (bytes_in < mark)
                @(negedge clk);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_off <= 1'b0;
            hold_offs++;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: at each rising edge, check a departing result against the
    // oldest expectation first, then predict a newly accepted byte.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        byte_report_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                    report_mismatch($sformatf("result %0d with no byte pending", reports_out));
                else
                begin
                    want = expected_reports.pop_front();
                    compare_field("gain_byte_valid",  8'(gain_byte_valid),
                                  8'(want.gain.byte_valid));
                    compare_field("gain_byte",        gain_byte,        want.gain.data);
                    compare_field("gain_byte_index",  gain_byte_index,  want.gain.index);
                    compare_field("gain_frame_done",  8'(gain_frame_done),
                                  8'(want.gain.done));
                    compare_field("gain_length",      gain_length,      want.gain.length);
                    compare_field("first_id",         first_id,         want.gain.first_id);
                    compare_field("second_id",        second_id,        want.gain.second_id);
                    compare_field("flag_value_valid", 8'(flag_value_valid),
                                  8'(want.flag.value_valid));
                    compare_field("flag_value",       flag_value,       want.flag.value);
                    compare_field("flag_value_index", flag_value_index, want.flag.index);
                    compare_field("flag_frame_done",  8'(flag_frame_done),
                                  8'(want.flag.done));
                    if (want.gain.done)
                        gain_frames++;
                    if (want.flag.done)
                        flag_frames++;
                    if ((want.gain.byte_valid && want.gain.index == COUNT_MAX) ||
                        (want.flag.value_valid && want.flag.index == COUNT_MAX))
                        saturated_reports++;
                end
                reports_out++;
            end
            if (in_valid && in_ready)
            begin
                expected_reports.push_back(predict_byte(rx_byte));
                bytes_in++;
            end
        end
        byte_taken <= rst_n && in_valid && in_ready;
    end

    // ---------------------------------------------------------------
    // Stimulus, reset and end of run
    // ---------------------------------------------------------------
    initial
    begin : stimulus_and_end
        int         pick;
        int         plen;
        int         cut;
        int         frame_no;
        logic [7:0] hdr [6];

        gain_st   = G_HASH;
        flag_st   = F_AT;
        gain_cnt  = 8'd0;
        flag_cnt  = 8'd0;
        id_first  = 8'd0;
        id_second = 8'd0;

        // Directed: extreme identifiers, "@Flag" bytes ignored by the gain
        // side while it waits for '=', one '=' and one '!' shared by both
        // frames, extreme payload bytes, then both frames with empty payload.
        push_text("#P");
        rx_pending.push_back(8'h00);
        rx_pending.push_back(CH_UNDER);
        rx_pending.push_back(8'hFF);
        push_text("@Flag=");
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(DIGIT_OFFSET);
        rx_pending.push_back(CH_BANG);
        push_text("#P5_7@Flag=!");

        // Random: mostly well-formed frames, some shared, some cut short,
        // some plain noise; one long frame of each kind for saturation.
        frame_no = 0;
        while (rx_pending.size() < ITEM_TARGET)
        begin
            frame_no++;
            pick = $urandom_range(0, 99);
            plen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (frame_no == 40)
                push_gain_frame(300);
            else if (frame_no == 90)
                push_flag_frame(290);
            else if (pick < 35)
                push_gain_frame(plen);
            else if (pick < 65)
                push_flag_frame(plen);
            else if (pick < 75)
            begin
                // both frames open, then share '=', payload and '!'
                rx_pending.push_back(CH_HASH);
                rx_pending.push_back(CH_P);
                rx_pending.push_back(8'($urandom_range(0, 255)));
                rx_pending.push_back(CH_UNDER);
                rx_pending.push_back(8'($urandom_range(0, 255)));
                push_text("@Flag=");
                push_payload(plen);
                rx_pending.push_back(CH_BANG);
            end
            else if (pick < 88)
            begin
                // header, possibly cut short, then garbage, maybe a resyncing '!'
                if ($urandom_range(0, 1) == 0)
                    hdr = '{CH_HASH, CH_P, 8'($urandom_range(0, 255)), CH_UNDER,
                            8'($urandom_range(0, 255)), CH_EQ};
                else
                    hdr = '{CH_AT, CH_F, CH_L, CH_A, CH_G, CH_EQ};
                cut = $urandom_range(1, 6);
                for (int i = 0; i < cut; i++)
                    rx_pending.push_back(hdr[i]);
                push_noise($urandom_range(1, 4));
                if ($urandom_range(0, 1) == 0)
                    rx_pending.push_back(CH_BANG);
            end
            else
            begin
                push_noise($urandom_range(1, 8));
                if ($urandom_range(0, 1) == 0)
                    rx_pending.push_back(CH_BANG);
            end
        end
        total_bytes = rx_pending.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (bytes_in < total_bytes)
            @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d bytes, %0d results checked, %0d gain and %0d flag frames closed",
                 bytes_in, reports_out, gain_frames, flag_frames);
        $display("%0d payload results at the saturated index, %0d long receiver hold-offs",
                 saturated_reports, hold_offs);
        if (mismatch_count == 0)
            $display("[command_frame_parser_core] OK");
        else
            $display("[command_frame_parser_core] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * 20);
        $display("[command_frame_parser_core] ERROR");
        $finish;
    end

endmodule

// ----- command_frame_parser_core.f -----
+incdir+sv
sv/cfp_pkg.sv
sv/cfp_gain_fsm.sv
sv/cfp_flag_fsm.sv
sv/command_frame_parser_core.sv
sv/cfp_checker.sv
verif/command_frame_parser_core_tb.sv
